// ===== design/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Shared constants, S-box tables and GF(2^8) helpers for the AES-128 block.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int KEY_WORDS = 44;
   localparam int NUM_ROUNDS = 10;
   localparam int KEY_ADDR_W = 6;
   localparam int ROUND_W = 4;

   // Operation codes on the func field.
   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW = 1'b1;

   typedef logic [127:0] block_type;

   // Control word from the sequencer to the round unit.
   typedef struct packed {
      logic load;
      logic decrypt;
      logic first;
      logic last;
   } round_ctl_type;

   localparam logic [7:0] FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   // Multiply by x in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Forward column mix on one 32-bit column, row 0 in top bits.
   function automatic logic [31:0] mix_fwd(input logic [31:0] col);
      logic [7:0] b [4];
      logic [7:0] o [4];
      for (int r = 0; r < 4; r++) b[r] = col[31-8*r -: 8];
      for (int r = 0; r < 4; r++) begin
         o[r] = xtime(b[r]) ^ xtime(b[(r+1)%4]) ^ b[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
      end
      return {o[0], o[1], o[2], o[3]};
   endfunction

   // Inverse column mix: coefficients 0e, 0b, 0d, 09.
   function automatic logic [31:0] mix_inv(input logic [31:0] col);
      logic [7:0] b [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] o [4];
      for (int r = 0; r < 4; r++) begin
         b[r] = col[31-8*r -: 8];
         x2[r] = xtime(b[r]);
         x4[r] = xtime(x2[r]);
         x8[r] = xtime(x4[r]);
      end
      for (int r = 0; r < 4; r++) begin
         o[r] = (x8[r] ^ x4[r] ^ x2[r])
              ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ b[(r+1)%4])
              ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ b[(r+2)%4])
              ^ (x8[(r+3)%4] ^ b[(r+3)%4]);
      end
      return {o[0], o[1], o[2], o[3]};
   endfunction

endpackage

// ===== design/aes_key_sched.sv =====
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the 128-bit key into 44 round-key words, one word per cycle, and
// serves one full 128-bit round key per cycle to the round unit.
// ----------------------------------------------------------------------------
module aes_key_sched
   import aes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         expand,
   input  logic [127:0] key,
   input  logic [ROUND_W-1:0] rd_round,
   output logic [127:0] rd_key,
   output logic         busy
);

   // Round keys are stored as 11 rows of four words.
   logic [127:0] key_mem [NUM_ROUNDS+1];
   logic [127:0] rd_key_ff;

   logic               run_ff, run_in;
   logic [KEY_ADDR_W-1:0] idx_ff, idx_in;
   logic [31:0]        w0_ff, w1_ff, w2_ff, w3_ff;
   logic [31:0]        w0_in, w1_in, w2_in, w3_in;
   logic [127:0]       row_ff, row_in;
   logic [7:0]         rcon_ff, rcon_in;
   logic [31:0]        tmp;
   logic [31:0]        new_word;

   // Next word: rotate, substitute and add rcon on the first word of a row.
   always_comb begin
      tmp = w3_ff;
      if (idx_ff[1:0] == 2'd0) begin
         tmp = {FWD_BOX[w3_ff[23:16]], FWD_BOX[w3_ff[15:8]], FWD_BOX[w3_ff[7:0]],
                FWD_BOX[w3_ff[31:24]]} ^ {rcon_ff, 24'd0};
      end
      new_word = w0_ff ^ tmp;
   end

   // Sequencer state for the expansion.
   always_comb begin
      run_in = run_ff;
      idx_in = idx_ff;
      rcon_in = rcon_ff;
      {w0_in, w1_in, w2_in, w3_in} = {w0_ff, w1_ff, w2_ff, w3_ff};
      row_in = row_ff;
      if (expand) begin
         run_in = 1'b1;
         idx_in = KEY_ADDR_W'(4);
         rcon_in = 8'h01;
         {w0_in, w1_in, w2_in, w3_in} = key;
         row_in = key;
      end else if (run_ff) begin
         {w0_in, w1_in, w2_in, w3_in} = {w1_ff, w2_ff, w3_ff, new_word};
         row_in = {row_ff[95:0], new_word};
         idx_in = idx_ff + KEY_ADDR_W'(1);
         if (idx_ff[1:0] == 2'd0) begin
            rcon_in = xtime(rcon_ff);
         end
         if (idx_ff == KEY_ADDR_W'(KEY_WORDS - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      idx_ff <= idx_in;
      rcon_ff <= rcon_in;
      {w0_ff, w1_ff, w2_ff, w3_ff} <= {w0_in, w1_in, w2_in, w3_in};
      row_ff <= row_in;
   end

   // Round-key memory: one row written when its fourth word is done.
   always_ff @(posedge clock) begin
      if (expand) begin
         key_mem[0] <= key;
      end else if (run_ff && idx_ff[1:0] == 2'd3) begin
         key_mem[ROUND_W'(idx_ff[KEY_ADDR_W-1:2])] <= {row_ff[95:0], new_word};
      end
      rd_key_ff <= key_mem[rd_round];
   end

   assign rd_key = rd_key_ff;
   assign busy = run_ff;

endmodule

// ===== design/aes_round_unit.sv =====
// ----------------------------------------------------------------------------
// AES round unit
// Holds the 128-bit state and applies one full round per cycle, forward or
// inverse, as selected by the sequencer.
// ----------------------------------------------------------------------------
module aes_round_unit
   import aes_pkg::*;
(
   input  logic          clock,
   input  round_ctl_type ctl,
   input  logic [127:0]  data,
   input  logic [127:0]  round_key,
   output logic [127:0]  state
);

   logic [127:0] state_ff, state_in;
   logic [7:0]   sb [16];
   logic [127:0] shifted;
   logic [127:0] mixed;
   logic [127:0] inv_added;

   // Substitute and shift rows, byte 4c+r in row r, column c.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sb[4*c+r] = ctl.decrypt
               ? INV_BOX[state_ff[127-8*(4*((c-r+4)%4)+r) -: 8]]
               : FWD_BOX[state_ff[127-8*(4*((c+r)%4)+r) -: 8]];
         end
      end
      for (int k = 0; k < 16; k++) shifted[127-8*k -: 8] = sb[k];
      inv_added = shifted ^ round_key;
      for (int c = 0; c < 4; c++) begin
         mixed[127-32*c -: 32] = ctl.decrypt ? mix_inv(inv_added[127-32*c -: 32])
                                             : mix_fwd(shifted[127-32*c -: 32]);
      end
   end

   // Next state: load of the input block, initial key add, middle round or final round.
   always_comb begin
      if (ctl.load) begin
         state_in = data;
      end else if (ctl.first) begin
         state_in = state_ff ^ round_key;
      end else if (ctl.last) begin
         state_in = shifted ^ round_key;
      end else if (ctl.decrypt) begin
         state_in = mixed;
      end else begin
         state_in = mixed ^ round_key;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign state = state_ff;

endmodule

// ===== design/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher
// A request runs through a load step, eleven key-add and round steps and a
// done step that registers the result; the rsp_valid strobe follows it.
// Busy stays high from acceptance through the done step, so a new word is
// taken only after the last one is done.
// A key write starts the key expansion; busy stays high during it.
// Reset is synchronous and clears the key registers and the sequencer.
// ----------------------------------------------------------------------------
module aes128_block_cipher
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_ROUND = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [63:0]        key_high_ff, key_low_ff;
   logic [63:0]        key_high_in, key_low_in;
   logic [1:0]         st_ff, st_in;
   logic [ROUND_W-1:0] step_ff, step_in;
   logic               dec_ff, dec_in;
   logic [127:0]       data_ff;
   logic               valid_ff, valid_in;
   logic               key_busy;
   logic [ROUND_W-1:0] rd_round;
   logic [127:0]       rd_key;
   logic [127:0]       state;
   round_ctl_type      ctl;
   logic               accept;

   // Key registers; the expansion starts from the value being written.
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in = key_low_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_data;
            CSR_KEY_LOW:  key_low_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff <= key_low_in;
      end
   end

   aes_key_sched u_sched (
      .clock    (clock),
      .reset    (reset),
      .expand   (csr_write),
      .key      ({key_high_in, key_low_in}),
      .rd_round (rd_round),
      .rd_key   (rd_key),
      .busy     (key_busy)
   );

   assign accept = start && !busy;

   // Round index in key memory order for the current step.
   always_comb begin
      rd_round = dec_ff ? ROUND_W'(NUM_ROUNDS) - step_ff : step_ff;
   end

   // Sequencer: fetch key, then one round per cycle with the next key read.
   always_comb begin
      st_in = st_ff;
      step_in = step_ff;
      dec_in = dec_ff;
      valid_in = 1'b0;
      ctl = '0;
      ctl.decrypt = dec_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               st_in = ST_FETCH;
               step_in = '0;
               dec_in = (req_func == FUNC_DECRYPT);
            end
         end
         ST_FETCH: begin
            ctl.load = 1'b1;
            st_in = ST_ROUND;
            step_in = ROUND_W'(1);
         end
         ST_ROUND: begin
            ctl.first = (step_ff == ROUND_W'(1));
            ctl.last = (step_ff == ROUND_W'(NUM_ROUNDS + 1));
            step_in = step_ff + ROUND_W'(1);
            if (ctl.last) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         valid_ff <= valid_in;
      end
      step_ff <= step_in;
      dec_ff <= dec_in;
      if (accept) begin
         data_ff <= {req_data_high, req_data_low};
      end
   end

   aes_round_unit u_round (
      .clock     (clock),
      .ctl       (ctl),
      .data      (data_ff),
      .round_key (rd_key),
      .state     (state)
   );

   logic [127:0] result_ff;
   always_ff @(posedge clock) begin
      if (st_ff == ST_DONE) begin
         result_ff <= state;
      end
   end

   assign busy = (st_ff != ST_IDLE) || key_busy;
   assign rsp_valid = valid_ff;
   assign rsp_result_high = result_ff[127:64];
   assign rsp_result_low = result_ff[63:0];

   // The result strobe is raised in the cycle after the done state.
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DONE) |=> rsp_valid) else $error("missing result strobe");
   // No start is taken while the key is being expanded.
   assert property (@(posedge clock) disable iff (reset)
      key_busy |-> !accept) else $error("start taken during key expansion");
   // A strobe is a single cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives single-block encrypt and decrypt commands under several keys and
// checks each result word against an in-bench AES-128 predictor. Key writes
// happen only while the block is idle; sender gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_top
   import aes_pkg::*;
();

   // Pending command word for the driver.
   typedef struct {
      logic        func;
      logic [63:0] data_high;
      logic [63:0] data_low;
   } cipher_cmd_type;

   typedef struct {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } cipher_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [63:0] req_data_high;
   logic [63:0] req_data_low;
   logic        rsp_valid;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_write;
   logic        csr_index;
   logic [63:0] csr_data;

   cipher_cmd_type cmd_queue[$];
   cipher_rsp_type expected_words[$];
   logic [31:0]    key_sched[KEY_WORDS];
   logic [63:0]    key_high_copy;
   logic [63:0]    key_low_copy;
   int             error_count;
   int             accepted_count;
   int             checked_count;
   int             gap_percent;
   bit             drain_done;
   logic           busy_at_edge;

   aes128_block_cipher u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_data_high(req_data_high),
      .req_data_low(req_data_low), .rsp_valid(rsp_valid),
      .rsp_result_high(rsp_result_high), .rsp_result_low(rsp_result_low),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // GF(2^8) multiply used by the column mixing.
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] v);
      logic [7:0] acc;
      acc = 8'h00;
      for (int k = 0; k < 4; k++) begin
         if (a[k]) acc ^= v;
         v = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   // Expand the current key into the 44-word schedule.
   function automatic void expand_schedule();
      logic [31:0] t;
      logic [7:0]  rc;
      key_sched[0] = key_high_copy[63:32];
      key_sched[1] = key_high_copy[31:0];
      key_sched[2] = key_low_copy[63:32];
      key_sched[3] = key_low_copy[31:0];
      rc = 8'h01;
      for (int i = 4; i < KEY_WORDS; i++) begin
         t = key_sched[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {FWD_BOX[t[31:24]], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]], FWD_BOX[t[7:0]]};
            t[31:24] ^= rc;
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end
         key_sched[i] = key_sched[i-4] ^ t;
      end
   endfunction

   // Full AES-128 block transform; state byte 4c+r is row r, column c.
   function automatic cipher_rsp_type aes_transform(input cipher_cmd_type cmd);
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] col[4];
      logic [7:0] m[4];
      cipher_rsp_type res;
      int src;
      for (int i = 0; i < 8; i++) begin
         s[i] = cmd.data_high[63-8*i -: 8];
         s[i+8] = cmd.data_low[63-8*i -: 8];
      end
      if (cmd.func == FUNC_ENCRYPT) m = '{8'h02, 8'h03, 8'h01, 8'h01};
      else m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      for (int step = 0; step <= NUM_ROUNDS; step++) begin
         int rnd;
         rnd = (cmd.func == FUNC_ENCRYPT) ? step : NUM_ROUNDS - step;
         if (step != 0) begin
            // Substitute bytes and rotate rows.
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  src = (cmd.func == FUNC_ENCRYPT) ? (c + r) % 4 : (c - r + 4) % 4;
                  t[4*c+r] = (cmd.func == FUNC_ENCRYPT) ? FWD_BOX[s[4*src+r]]
                                                        : INV_BOX[s[4*src+r]];
               end
            end
            s = t;
            if (cmd.func == FUNC_ENCRYPT && rnd != NUM_ROUNDS) begin
               for (int c = 0; c < 4; c++) begin
                  for (int r = 0; r < 4; r++) col[r] = s[4*c+r];
                  for (int r = 0; r < 4; r++)
                     s[4*c+r] = gf_mul(m[0], col[r]) ^ gf_mul(m[1], col[(r+1)%4])
                              ^ gf_mul(m[2], col[(r+2)%4]) ^ gf_mul(m[3], col[(r+3)%4]);
               end
            end
         end
         // Round key add.
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) s[4*c+r] ^= key_sched[rnd*4+c][31-8*r -: 8];
         end
         // Decryption mixes after the key add, except on the last round.
         if (cmd.func == FUNC_DECRYPT && step != 0 && rnd != 0) begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) col[r] = s[4*c+r];
               for (int r = 0; r < 4; r++)
                  s[4*c+r] = gf_mul(m[0], col[r]) ^ gf_mul(m[1], col[(r+1)%4])
                           ^ gf_mul(m[2], col[(r+2)%4]) ^ gf_mul(m[3], col[(r+3)%4]);
            end
         end
      end
      for (int i = 0; i < 8; i++) begin
         res.result_high[63-8*i -: 8] = s[i];
         res.result_low[63-8*i -: 8] = s[i+8];
      end
      return res;
   endfunction

   // One line per mismatch, and count it.
   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Busy as seen at the rising edge, for the driver's accept test.
   always @(posedge clock) busy_at_edge <= busy;

   // Driver: present the head of the command queue and predict on accept.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy_at_edge) begin
            // Previous word was accepted at the last rising edge.
            expected_words.push_back(aes_transform(cmd_queue.pop_front()));
            accepted_count++;
         end
         if (cmd_queue.size() > 0 && (start && busy_at_edge
               || $urandom_range(99, 0) >= gap_percent)) begin
            start <= 1'b1;
            req_func <= cmd_queue[0].func;
            req_data_high <= cmd_queue[0].data_high;
            req_data_low <= cmd_queue[0].data_low;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check each result word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            report_error("result word with nothing expected");
         end else begin
            cipher_rsp_type exp_word;
            exp_word = expected_words.pop_front();
            checked_count++;
            if (rsp_result_high !== exp_word.result_high)
               report_error($sformatf("result_high %h, expected %h",
                  rsp_result_high, exp_word.result_high));
            if (rsp_result_low !== exp_word.result_low)
               report_error($sformatf("result_low %h, expected %h",
                  rsp_result_low, exp_word.result_low));
         end
      end
   end

   // Write one key register while idle, then wait out the expansion.
   task automatic write_key(input logic index, input logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == CSR_KEY_HIGH) key_high_copy = value;
      else key_low_copy = value;
      expand_schedule();
      while (busy) @(negedge clock);
   endtask

   // Wait until every queued word is accepted and answered.
   task automatic drain();
      while (cmd_queue.size() > 0 || start || expected_words.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic add_cmd(input logic f, input logic [63:0] hi, input logic [63:0] lo);
      cipher_cmd_type c;
      c.func = f;
      c.data_high = hi;
      c.data_low = lo;
      cmd_queue.push_back(c);
   endtask

   // Stimulus and end of run.
   initial begin
      logic [63:0] vals[4];
      cipher_cmd_type c;
      start = 1'b0;
      reset = 1'b1;
      req_func = FUNC_ENCRYPT;
      req_data_high = '0;
      req_data_low = '0;
      csr_write = 1'b0;
      csr_index = CSR_KEY_HIGH;
      csr_data = '0;
      error_count = 0;
      accepted_count = 0;
      checked_count = 0;
      gap_percent = 0;
      drain_done = 0;
      key_high_copy = '0;
      key_low_copy = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: the standard test vector, then field extremes both ways.
      write_key(CSR_KEY_HIGH, 64'h0001020304050607);
      write_key(CSR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      add_cmd(FUNC_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
      add_cmd(FUNC_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      vals = '{64'h0, 64'hffffffffffffffff, 64'h8000000000000001, 64'h5555aaaa5555aaaa};
      for (int i = 0; i < 4; i++) begin
         add_cmd(FUNC_ENCRYPT, vals[i], vals[3-i]);
         add_cmd(FUNC_DECRYPT, vals[i], vals[3-i]);
      end
      drain();
      // Key extremes: all zeros and all ones.
      write_key(CSR_KEY_HIGH, 64'h0);
      write_key(CSR_KEY_LOW, 64'h0);
      add_cmd(FUNC_ENCRYPT, 64'h0, 64'h0);
      add_cmd(FUNC_DECRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff);
      drain();
      write_key(CSR_KEY_HIGH, 64'hffffffffffffffff);
      write_key(CSR_KEY_LOW, 64'hffffffffffffffff);
      add_cmd(FUNC_ENCRYPT, 64'hffffffffffffffff, 64'h0);
      add_cmd(FUNC_DECRYPT, 64'h0, 64'hffffffffffffffff);
      drain();

      // Random phases: new key each phase, varying sender gaps.
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: gap_percent = 0;
            1: gap_percent = 52;
            2: gap_percent = 0;
            default: gap_percent = 7;
         endcase
         write_key(($urandom_range(1, 0) != 0) ? CSR_KEY_LOW : CSR_KEY_HIGH, rand64());
         if ($urandom_range(1, 0) != 0) write_key(CSR_KEY_HIGH, rand64());
         for (int i = 0; i < 36; i++) begin
            c.func = 1'($urandom_range(1, 0));
            c.data_high = rand64();
            c.data_low = rand64();
            cmd_queue.push_back(c);
            // Round trips: decrypt what was just encrypted, and vice versa.
            if ($urandom_range(3, 0) == 0) begin
               cipher_rsp_type r;
               r = aes_transform(c);
               add_cmd(~c.func, r.result_high, r.result_low);
            end
         end
         drain();
      end
      drain_done = 1;
      $display("Ran %0d blocks (encrypt and decrypt) over 15 key settings;",
         accepted_count);
      $display("%0d result words checked.", checked_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #(12 * 400000);
      $display("Timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
